>>> hdl/ncs_pkg.sv
// shared constants and control structs for the nearest coprime search unit
package ncs_pkg;

  // width of every field on the item ports
  localparam int FIELD_W = 32;

  // entries in the queue between front end and search engine
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic coprime;
  } gcd_stat_t;

endpackage

>>> hdl/nearest_coprime_search_unit.sv
// top level of the nearest coprime search unit
//
//  channel   ports                                  handshake
//  -------   -------------------------------------  ---------------------------------
//  input     in_modulus, in_multiplier              beat when start && !busy
//  result    out_coprime_value                      beat when out_valid (one cycle)
//
// in the front end an item is captured, multiplied into the product register, then rounded into the queue
// the search engine picks each candidate, range checks it, and for an in-range candidate
// with nonzero value and modulus runs the binary gcd
// so the time per item is set by the candidates tried and the gcd loop
// the front end keeps taking items while the engine works, until the queue and both front stages are full
// reset clears the pipeline valids, queue pointers and engine state, no data
// results are never stalled: out_valid lasts exactly one cycle per result
module nearest_coprime_search_unit #(
  parameter int VALUE_BITS = 32,
  parameter int FRAC_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ncs_pkg::FIELD_W-1:0] in_modulus,
  input  logic [ncs_pkg::FIELD_W-1:0] in_multiplier,
  output logic                        out_valid,
  output logic [ncs_pkg::FIELD_W-1:0] out_coprime_value
);
  import ncs_pkg::*;

  // queue entry: round-up flag, rounded target, modulus
  localparam int JOB_W = 2 * VALUE_BITS + 1;

  q_stat_t               q_stat;
  logic                  q_push;
  logic                  q_pop;
  logic [JOB_W-1:0]      q_wdata;
  logic [JOB_W-1:0]      q_rdata;
  logic [VALUE_BITS-1:0] res_value;

  // front end: operand capture, product register, half-to-even rounding
  ncs_front #(
    .VALUE_BITS (VALUE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_modulus    (in_modulus),
    .in_multiplier (in_multiplier),
    .q_stat        (q_stat),
    .push          (q_push),
    .push_data     (q_wdata)
  );

  // decouples the stallable front end from the data-dependent search
  ncs_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  // candidate walk with its own gcd unit
  ncs_search #(
    .VALUE_BITS (VALUE_BITS)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .job       (q_rdata),
    .res_valid (out_valid),
    .res_value (res_value)
  );

  // result never exceeds a nonzero modulus; zero extension is exact while VALUE_BITS <= FIELD_W
  assign out_coprime_value = FIELD_W'(res_value);

endmodule

>>> hdl/ncs_front.sv
// front end: takes items, forms n*q and rounds it half to even
module ncs_front #(
  parameter int VALUE_BITS = 32,
  parameter int FRAC_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ncs_pkg::FIELD_W-1:0]   in_modulus,
  input  logic [ncs_pkg::FIELD_W-1:0]   in_multiplier,
  input  ncs_pkg::q_stat_t              q_stat,
  output logic                          push,
  output logic [2*VALUE_BITS:0]         push_data
);
  import ncs_pkg::*;

  localparam int Q_W    = (FRAC_BITS < FIELD_W) ? FRAC_BITS : FIELD_W;
  localparam int PROD_W = VALUE_BITS + Q_W;
  localparam int WIDE_W = PROD_W + FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

  logic                  s1_v_r, s1_v_nxt;
  logic [VALUE_BITS-1:0] s1_n_r, s1_n_nxt;
  logic [Q_W-1:0]        s1_q_r, s1_q_nxt;
  logic                  s2_v_r, s2_v_nxt;
  logic [VALUE_BITS-1:0] s2_n_r, s2_n_nxt;
  logic [PROD_W-1:0]     s2_prod_r, s2_prod_nxt;

  logic                  accept;
  logic                  s2_load;
  logic [WIDE_W-1:0]     prod_ext;
  logic [WIDE_W-1:0]     ipart_w;
  logic [VALUE_BITS-1:0] ipart;
  logic [FRAC_BITS-1:0]  fpart;
  logic                  round_up;
  logic [VALUE_BITS-1:0] rounded;

  // stage one stalls only when the product stage is held by a full queue
  assign busy    = s1_v_r && s2_v_r && q_stat.full;
  assign accept  = start && !busy;
  assign push    = s2_v_r && !q_stat.full;
  assign s2_load = s1_v_r && (!s2_v_r || push);

  always_comb begin
    s1_v_nxt    = s1_v_r;
    s1_n_nxt    = s1_n_r;
    s1_q_nxt    = s1_q_r;
    s2_v_nxt    = s2_v_r;
    s2_n_nxt    = s2_n_r;
    s2_prod_nxt = s2_prod_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
      s1_n_nxt = in_modulus[VALUE_BITS-1:0];
      s1_q_nxt = in_multiplier[Q_W-1:0];
    end else if (s2_load) begin
      s1_v_nxt = 1'b0;
    end
    if (s2_load) begin
      s2_v_nxt    = 1'b1;
      s2_n_nxt    = s1_n_r;
      s2_prod_nxt = PROD_W'(s1_n_r) * PROD_W'(s1_q_r);
    end else if (push) begin
      s2_v_nxt = 1'b0;
    end
  end

  // round half to even on the registered product
  always_comb begin
    prod_ext = WIDE_W'(s2_prod_r);
    ipart_w  = prod_ext >> FRAC_BITS;
    ipart    = ipart_w[VALUE_BITS-1:0];
    fpart    = prod_ext[FRAC_BITS-1:0];
    round_up = (fpart > HALF) || ((fpart == HALF) && ipart[0]);
    rounded  = ipart + VALUE_BITS'(round_up);
  end

  assign push_data = {round_up, rounded, s2_n_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_n_r    <= s1_n_nxt;
    s1_q_r    <= s1_q_nxt;
    s2_n_r    <= s2_n_nxt;
    s2_prod_r <= s2_prod_nxt;
  end

endmodule

>>> hdl/ncs_queue.sv
// short queue of rounded jobs between front end and search engine
module ncs_queue #(
  parameter int DATA_W = 65
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output ncs_pkg::q_stat_t  stat
);
  import ncs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  logic [DATA_W-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == DEPTH_C);
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != DEPTH_C) || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue read while empty");

endmodule

>>> hdl/ncs_gcd.sv
// iterative binary gcd that tells whether two nonzero values are coprime
module ncs_gcd #(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [W-1:0]       a,
  input  logic [W-1:0]       b,
  output ncs_pkg::gcd_stat_t stat
);
  import ncs_pkg::*;

  localparam logic [W-1:0] ONE = W'(1);

  logic [W-1:0] a_r, a_nxt;
  logic [W-1:0] b_r, b_nxt;
  logic         run_r, run_nxt;
  logic         done_r, done_nxt;
  logic         cop_r, cop_nxt;

  assign stat.busy    = run_r;
  assign stat.done    = done_r;
  assign stat.coprime = cop_r;

  // odd gcd is kept once the operands are not both even, so halving is safe
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cop_nxt  = cop_r;
    if (start) begin
      a_nxt = a;
      b_nxt = b;
      if (!a[0] && !b[0]) begin
        done_nxt = 1'b1;
        cop_nxt  = 1'b0;
        run_nxt  = 1'b0;
      end else begin
        run_nxt = 1'b1;
      end
    end else if (run_r) begin
      if ((a_r == ONE) || (b_r == ONE)) begin
        done_nxt = 1'b1;
        cop_nxt  = 1'b1;
        run_nxt  = 1'b0;
      end else if (a_r == b_r) begin
        done_nxt = 1'b1;
        cop_nxt  = 1'b0;
        run_nxt  = 1'b0;
      end else if (!a_r[0] || !b_r[0]) begin
        if (!a_r[0]) a_nxt = a_r >> 1;
        if (!b_r[0]) b_nxt = b_r >> 1;
      end else if (a_r > b_r) begin
        a_nxt = a_r - b_r;
      end else begin
        b_nxt = b_r - a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    cop_r <= cop_nxt;
  end

endmodule

>>> hdl/ncs_search.sv
// search engine: walks candidates outward from the rounded target
module ncs_search #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ncs_pkg::q_stat_t      q_stat,
  output logic                  pop,
  input  logic [2*VALUE_BITS:0] job,
  output logic                  res_valid,
  output logic [VALUE_BITS-1:0] res_value
);
  import ncs_pkg::*;

  localparam int CW = VALUE_BITS + 2;
  localparam logic [VALUE_BITS-1:0] V_ONE = VALUE_BITS'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_NEXT,
    S_CHECK,
    S_WAIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] n_r, n_nxt;
  logic                  up_r, up_nxt;
  logic                  side_r, side_nxt;
  logic [CW-1:0]         cand_r, cand_nxt;
  logic [CW-1:0]         lo_r, lo_nxt;
  logic [CW-1:0]         hi_r, hi_nxt;
  logic                  out_v_r, out_v_nxt;
  logic [VALUE_BITS-1:0] res_r, res_nxt;

  logic [VALUE_BITS-1:0] job_n;
  logic [VALUE_BITS-1:0] job_r;
  logic                  job_up;
  logic [CW-1:0]         job_c;
  logic [CW-1:0]         n_ext;
  logic [VALUE_BITS-1:0] cand_low;
  logic                  out_of_range;
  logic                  take_lo;
  logic                  gcd_start;
  gcd_stat_t             gcd_st;

  assign job_n  = job[VALUE_BITS-1:0];
  assign job_r  = job[2*VALUE_BITS-1:VALUE_BITS];
  assign job_up = job[2*VALUE_BITS];
  assign job_c  = CW'(job_r);

  assign n_ext    = CW'(n_r);
  assign cand_low = cand_r[VALUE_BITS-1:0];
  // negative candidates and candidates above a nonzero modulus are skipped
  assign out_of_range = cand_r[CW-1] || ((n_r != '0) && (cand_r > n_ext));
  // rounded up: low side goes first at each distance
  assign take_lo = up_r ^ side_r;

  assign pop       = (state_r == S_IDLE) && !q_stat.empty;
  assign res_valid = out_v_r;
  assign res_value = res_r;

  ncs_gcd #(.W(VALUE_BITS)) u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a     (cand_low),
    .b     (n_r),
    .stat  (gcd_st)
  );

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    up_nxt    = up_r;
    side_nxt  = side_r;
    cand_nxt  = cand_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    out_v_nxt = 1'b0;
    res_nxt   = res_r;
    gcd_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          n_nxt     = job_n;
          up_nxt    = job_up;
          side_nxt  = 1'b0;
          cand_nxt  = job_c;
          lo_nxt    = job_c - CW'(1);
          hi_nxt    = job_c + CW'(1);
          state_nxt = S_CHECK;
        end
      end
      S_NEXT: begin
        side_nxt = !side_r;
        if (take_lo) begin
          cand_nxt = lo_r;
          lo_nxt   = lo_r - CW'(1);
        end else begin
          cand_nxt = hi_r;
          hi_nxt   = hi_r + CW'(1);
        end
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (out_of_range) begin
          state_nxt = S_NEXT;
        end else if (n_r == '0) begin
          // gcd with zero is the value itself
          if (cand_low == V_ONE) begin
            out_v_nxt = 1'b1;
            res_nxt   = cand_low;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_NEXT;
          end
        end else if (cand_low == '0) begin
          if (n_r == V_ONE) begin
            out_v_nxt = 1'b1;
            res_nxt   = cand_low;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_NEXT;
          end
        end else begin
          gcd_start = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (gcd_st.done) begin
          if (gcd_st.coprime) begin
            out_v_nxt = 1'b1;
            res_nxt   = cand_low;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_NEXT;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
    n_r    <= n_nxt;
    up_r   <= up_nxt;
    side_r <= side_nxt;
    cand_r <= cand_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    res_r  <= res_nxt;
  end

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |=> !out_v_r)
    else $error("result strobe held for more than one cycle");

  a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (n_r != '0)) |-> (res_r <= n_r))
    else $error("result above modulus");

  a_gcd_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_start |-> !gcd_st.busy)
    else $error("gcd started while running");

endmodule
